[hdl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Token kinds, operator codes, status codes and the request and response
// words between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_W         = 32;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_OPER   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [VALUE_W-1:0] Q_ONE       = 32'h0001_0000;
  localparam logic [VALUE_W-1:0] Q_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [VALUE_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] Q_MIN       = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_BADEXP   = 3'd4
  } status_t;

  typedef struct packed {
    logic               start;
    op_t                op;
    logic [VALUE_W-1:0] a;    // left-hand side (second popped)
    logic [VALUE_W-1:0] b;    // right-hand side (first popped)
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] value;
    logic               sat;
    logic               dz;
    logic               bad;
  } alu_rsp_t;

endpackage

[hdl/pse_ram.sv]
// ----------------------------------------------------------------------------
// pse_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/pse_alu.sv]
// ----------------------------------------------------------------------------
// pse_alu: shared Q16.16 arithmetic unit
// Add/sub in one pass, multiply and power through one registered multiplier,
// divide and modulo through a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  pse_pkg::alu_req_t  req,
  output pse_pkg::alu_rsp_t  rsp
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_SAT,
    A_DIV,
    A_FIX
  } astate_t;

  astate_t            state_r;
  pse_pkg::op_t       op_r;
  logic [31:0]        acc_r;
  logic [31:0]        base_r;
  logic signed [63:0] prod_r;
  logic [47:0]        quo_r;
  logic [31:0]        rem_r;
  logic [31:0]        dsr_r;
  logic [5:0]         step_r;
  logic               neg_r;
  logic               done_r;
  logic [31:0]        value_r;
  logic               sat_r;
  logic               dz_r;
  logic               bad_r;

  logic [32:0]        sum_s;
  logic               sum_ovf;
  logic [31:0]        sum_val;
  logic [31:0]        abs_a;
  logic [31:0]        abs_b;
  logic [16:0]        ia;
  logic [16:0]        ib;
  logic [16:0]        neg_ia;
  logic [16:0]        neg_ib;
  logic [15:0]        abs_ia;
  logic [15:0]        abs_ib;
  logic signed [63:0] shifted;
  logic               mul_ovf;
  logic [31:0]        mul_val;
  logic [32:0]        rem_sh;
  logic [33:0]        diff;
  logic               q_bit;
  logic [31:0]        rem_next;
  logic               div_ovf;
  logic [31:0]        div_val;
  logic [31:0]        mod_pos;
  logic [31:0]        mod_val;
  logic               exp_bad;

  always_comb begin
    if (req.op == pse_pkg::OP_SUB) begin
      sum_s = {req.a[31], req.a} - {req.b[31], req.b};
    end else begin
      sum_s = {req.a[31], req.a} + {req.b[31], req.b};
    end
    sum_ovf = sum_s[32] != sum_s[31];
    sum_val = sum_ovf ? (sum_s[32] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX) : sum_s[31:0];

    abs_a = req.a[31] ? 32'(-req.a) : req.a;
    abs_b = req.b[31] ? 32'(-req.b) : req.b;

    // integer parts truncated toward zero
    ia     = {req.a[31], req.a[31:16]} + 17'(req.a[31] && (req.a[15:0] != '0));
    ib     = {req.b[31], req.b[31:16]} + 17'(req.b[31] && (req.b[15:0] != '0));
    neg_ia = -ia;
    neg_ib = -ib;
    abs_ia = ia[16] ? neg_ia[15:0] : ia[15:0];
    abs_ib = ib[16] ? neg_ib[15:0] : ib[15:0];

    exp_bad = (req.b[15:0] != '0) || req.b[31] || (req.b[30:21] != '0);

    shifted = prod_r >>> 16;
    mul_ovf = !((&shifted[63:31]) || (~|shifted[63:31]));
    mul_val = mul_ovf ? (shifted[63] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX) : shifted[31:0];

    rem_sh   = {rem_r, quo_r[47]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
    q_bit    = !diff[33];
    rem_next = q_bit ? diff[31:0] : rem_sh[31:0];

    div_ovf = neg_r ? (quo_r > 48'h0000_8000_0000) : (quo_r > 48'h0000_7FFF_FFFF);
    if (div_ovf) begin
      div_val = neg_r ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
    end else begin
      div_val = neg_r ? 32'(-quo_r[31:0]) : quo_r[31:0];
    end

    mod_pos = {rem_r[15:0], 16'h0000};
    mod_val = neg_r ? 32'(-mod_pos) : mod_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      sat_r   <= 1'b0;
      dz_r    <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            op_r  <= req.op;
            sat_r <= 1'b0;
            dz_r  <= 1'b0;
            bad_r <= 1'b0;
            unique case (req.op)
              pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
                value_r <= sum_val;
                sat_r   <= sum_ovf;
                done_r  <= 1'b1;
              end
              pse_pkg::OP_MUL: begin
                acc_r   <= req.b;
                base_r  <= req.a;
                step_r  <= 6'd1;
                state_r <= A_MUL;
              end
              pse_pkg::OP_DIV: begin
                if (req.b == '0) begin
                  value_r <= '0;
                  dz_r    <= 1'b1;
                  done_r  <= 1'b1;
                end else begin
                  quo_r   <= {abs_a, 16'h0000};
                  rem_r   <= '0;
                  dsr_r   <= abs_b;
                  neg_r   <= req.a[31] ^ req.b[31];
                  step_r  <= 6'd48;
                  state_r <= A_DIV;
                end
              end
              pse_pkg::OP_MOD: begin
                if (ib == '0) begin
                  value_r <= '0;
                  dz_r    <= 1'b1;
                  done_r  <= 1'b1;
                end else begin
                  quo_r   <= {abs_ia, 32'h0000_0000};
                  rem_r   <= '0;
                  dsr_r   <= {16'h0000, abs_ib};
                  neg_r   <= ia[16];
                  step_r  <= 6'd16;
                  state_r <= A_DIV;
                end
              end
              pse_pkg::OP_POW: begin
                if (exp_bad) begin
                  value_r <= '0;
                  bad_r   <= 1'b1;
                  done_r  <= 1'b1;
                end else if (req.b[20:16] == '0) begin
                  value_r <= pse_pkg::Q_ONE;
                  done_r  <= 1'b1;
                end else begin
                  acc_r   <= pse_pkg::Q_ONE;
                  base_r  <= req.a;
                  step_r  <= {1'b0, req.b[20:16]};
                  state_r <= A_MUL;
                end
              end
              default: begin
                value_r <= '0;
                done_r  <= 1'b1;
              end
            endcase
          end
        end
        A_MUL: begin
          prod_r  <= $signed(acc_r) * $signed(base_r);
          state_r <= A_SAT;
        end
        A_SAT: begin
          acc_r <= mul_val;
          sat_r <= sat_r | mul_ovf;
          if (step_r == 6'd1) begin
            value_r <= mul_val;
            done_r  <= 1'b1;
            state_r <= A_IDLE;
          end else begin
            step_r  <= step_r - 6'd1;
            state_r <= A_MUL;
          end
        end
        A_DIV: begin
          quo_r  <= {quo_r[46:0], q_bit};
          rem_r  <= rem_next;
          step_r <= step_r - 6'd1;
          if (step_r == 6'd1) begin
            state_r <= A_FIX;
          end
        end
        A_FIX: begin
          if (op_r == pse_pkg::OP_MOD) begin
            value_r <= mod_val;
          end else begin
            value_r <= div_val;
            sat_r   <= div_ovf;
          end
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp = '{done: done_r, value: value_r, sat: sat_r, dz: dz_r, bad: bad_r};

endmodule

[hdl/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: Q16.16 postfix expression evaluator
// Token sequencer over a RAM stack, driving the shared arithmetic unit.
// ----------------------------------------------------------------------------
// Each accepted token (start high while busy is low) gives exactly one result
// word, shown for one cycle with out_valid high; the receiver cannot stall, so
// it must take every strobe. A push, an unused operator code or an unused mode
// gives its result in the cycle after acceptance and busy stays low, so
// tokens of this kind may come back to back. A finish token holds busy
// through one registered stack read. An operator token holds busy through its
// two stack reads and a load state, then the arithmetic unit: add/subtract in
// one pass, multiply through the registered multiplier and a saturation step,
// divide and modulo through the restoring divider (one quotient bit a cycle,
// then a sign fixup), power by one multiply per exponent step for exponents
// 1..31; exponent 0, a bad exponent and a zero divisor answer directly. The
// result strobes as busy falls. No clearing pass is needed after reset.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_op_code,
  input  logic [31:0] in_operand_value,
  output logic        out_valid,
  output logic [31:0] out_result_value,
  output logic [2:0]  out_status,
  output logic [4:0]  out_stack_depth
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_FIRST,
    S_POP_SECOND,
    S_LOAD,
    S_CALC,
    S_FINISH
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  pse_pkg::op_t      op_r;
  logic              fin_r;
  logic              f1_r;
  logic              f2_r;
  logic              under_r;
  logic [31:0]       first_r;
  logic              out_valid_r;
  logic [31:0]       out_value_r;
  pse_pkg::status_t  out_status_r;
  logic [4:0]        out_depth_r;

  logic              accept;
  logic              ram_wen;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic [CW-1:0]     cnt_dec;
  logic [CW-1:0]     cnt_inc;
  logic              stack_full;
  logic [31:0]       second_val;
  pse_pkg::alu_req_t alu_req;
  pse_pkg::alu_rsp_t alu_rsp;

  assign busy       = state_r != S_IDLE;
  assign accept     = start && !busy;
  assign cnt_dec    = cnt_r - CW'(1);
  assign cnt_inc    = cnt_r + CW'(1);
  assign stack_full = cnt_r >= CW'(STACK_DEPTH);
  assign ram_raddr  = cnt_dec[AW-1:0];
  assign second_val = f2_r ? ram_rdata : pse_pkg::Q_MINUS_ONE;

  always_comb begin
    ram_wen   = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = in_operand_value;
    if (accept && (in_mode == pse_pkg::MODE_PUSH) && !stack_full) begin
      ram_wen = 1'b1;
    end else if ((state_r == S_CALC) && alu_rsp.done) begin
      ram_wen   = 1'b1;
      ram_wdata = alu_rsp.value;
    end
  end

  assign alu_req = '{start: state_r == S_LOAD, op: op_r, a: second_val, b: first_r};

  pse_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .wen  (ram_wen),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pse_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .rsp  (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            under_r <= 1'b0;
            op_r    <= pse_pkg::op_t'(in_op_code);
            if (in_mode == pse_pkg::MODE_PUSH) begin
              out_valid_r <= 1'b1;
              out_value_r <= in_operand_value;
              if (stack_full) begin
                out_status_r <= pse_pkg::ST_OVERFLOW;
                out_depth_r  <= 5'(cnt_r);
              end else begin
                out_status_r <= pse_pkg::ST_OK;
                out_depth_r  <= 5'(cnt_inc);
                cnt_r        <= cnt_inc;
              end
            end else if ((in_mode == pse_pkg::MODE_OPER) && (in_op_code <= pse_pkg::OP_POW)) begin
              fin_r   <= 1'b0;
              state_r <= S_POP_FIRST;
            end else if (in_mode == pse_pkg::MODE_FINISH) begin
              fin_r   <= 1'b1;
              state_r <= S_POP_FIRST;
            end else begin
              out_valid_r  <= 1'b1;
              out_value_r  <= '0;
              out_status_r <= pse_pkg::ST_OK;
              out_depth_r  <= 5'(cnt_r);
            end
          end
        end
        S_POP_FIRST: begin
          f1_r <= cnt_r != '0;
          if (cnt_r == '0) begin
            under_r <= 1'b1;
          end else begin
            cnt_r <= cnt_dec;
          end
          state_r <= fin_r ? S_FINISH : S_POP_SECOND;
        end
        S_POP_SECOND: begin
          first_r <= f1_r ? ram_rdata : pse_pkg::Q_MINUS_ONE;
          f2_r    <= cnt_r != '0;
          if (cnt_r == '0) begin
            under_r <= 1'b1;
          end else begin
            cnt_r <= cnt_dec;
          end
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (alu_rsp.done) begin
            cnt_r       <= cnt_inc;
            out_valid_r <= 1'b1;
            out_value_r <= alu_rsp.value;
            out_depth_r <= 5'(cnt_inc);
            priority if (under_r) begin
              out_status_r <= pse_pkg::ST_UNDERFLOW;
            end else if (alu_rsp.dz) begin
              out_status_r <= pse_pkg::ST_DIVZERO;
            end else if (alu_rsp.bad) begin
              out_status_r <= pse_pkg::ST_BADEXP;
            end else if (alu_rsp.sat) begin
              out_status_r <= pse_pkg::ST_OVERFLOW;
            end else begin
              out_status_r <= pse_pkg::ST_OK;
            end
            state_r <= S_IDLE;
          end
        end
        S_FINISH: begin
          out_valid_r  <= 1'b1;
          out_value_r  <= f1_r ? ram_rdata : pse_pkg::Q_MINUS_ONE;
          out_status_r <= under_r ? pse_pkg::ST_UNDERFLOW : pse_pkg::ST_OK;
          out_depth_r  <= 5'(cnt_r);
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_stack_depth  = out_depth_r;

endmodule

[hdl/pse_checker.sv]
// ----------------------------------------------------------------------------
// pse_checker: port-level checks of the postfix stack evaluator
// Watches the command and result ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [4:0] out_stack_depth
);

  // a result word only follows an accepted token or running work
  a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result word without a token");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted token neither running nor answered");

  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == pse_pkg::MODE_PUSH)) |=> (out_valid && !busy))
    else $error("push word not returned in the next cycle");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("work ended without a result word");

  a_underflow_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == pse_pkg::ST_UNDERFLOW)) |-> (out_stack_depth <= 5'd1))
    else $error("underflow with a deep stack");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

[tb/sv/pse_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_result_checker: result predictor and scoreboard for the postfix evaluator
// Tracks its own Q16.16 stack from every accepted token, queues the expected
// result word and compares each strobed result word field by field.
// ----------------------------------------------------------------------------
module pse_result_checker
  import pse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_op_code,
  input  logic [31:0] in_operand_value,
  input  logic        out_valid,
  input  logic [31:0] out_result_value,
  input  logic [2:0]  out_status,
  input  logic [4:0]  out_stack_depth,
  output int          expected_left,
  output int          words_checked,
  output int          fail_count
);

  localparam int DEPTH = STACK_DEPTH_DEF;

  typedef struct {
    logic [31:0] value;
    status_t     status;
    logic [4:0]  depth;
  } token_result_t;

  logic [31:0]   value_mem [DEPTH];
  int unsigned   fill_level = 0;
  token_result_t result_q [$];
  token_result_t want;

  initial begin
    expected_left = 0;
    words_checked = 0;
    fail_count    = 0;
  end

  function automatic logic [31:0] clamp32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // product floored to Q16.16, then saturated
  function automatic logic [31:0] qmul_fix(input logic [31:0] x, input logic [31:0] y,
                                           inout bit sat);
    longint p;
    p = longint'(signed'(x)) * longint'(signed'(y));
    return clamp32(p >>> 16, sat);
  endfunction

  function automatic logic [31:0] pop_entry(inout bit under);
    if (fill_level == 0) begin
      under = 1'b1;
      return Q_MINUS_ONE;
    end
    fill_level--;
    return value_mem[fill_level];
  endfunction

  function automatic token_result_t evaluate_token(input logic [1:0] mode,
                                                   input logic [2:0] code,
                                                   input logic [31:0] operand);
    token_result_t r;
    bit            under, sat, dz, bad;
    logic [31:0]   rhs, lhs, acc;
    longint        a, b, ia, ib;
    int            n;
    r.value = '0;
    r.status = ST_OK;
    under = 1'b0;
    sat = 1'b0;
    dz = 1'b0;
    bad = 1'b0;
    if (mode == MODE_PUSH) begin
      r.value = operand;
      if (fill_level >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        value_mem[fill_level] = operand;
        fill_level++;
      end
    end else if (mode == MODE_OPER && code <= OP_POW) begin
      rhs = pop_entry(under);
      lhs = pop_entry(under);
      a = longint'(signed'(lhs));
      b = longint'(signed'(rhs));
      case (op_t'(code))
        OP_ADD: r.value = clamp32(a + b, sat);
        OP_SUB: r.value = clamp32(a - b, sat);
        OP_MUL: r.value = qmul_fix(lhs, rhs, sat);
        OP_DIV: begin
          if (b == 0) dz = 1'b1;
          else r.value = clamp32((a * 65536) / b, sat);
        end
        OP_MOD: begin
          ia = a / 65536;
          ib = b / 65536;
          if (ib == 0) dz = 1'b1;
          else r.value = 32'((ia % ib) * 65536);
        end
        default: begin
          if (rhs[15:0] != 16'h0 || b < 0 || b / 65536 > 31) begin
            bad = 1'b1;
          end else begin
            n = int'(b / 65536);
            acc = Q_ONE;
            for (int k = 0; k < n; k++) acc = qmul_fix(acc, lhs, sat);
            r.value = acc;
          end
        end
      endcase
      value_mem[fill_level] = r.value;
      fill_level++;
      if (under) r.status = ST_UNDERFLOW;
      else if (dz) r.status = ST_DIVZERO;
      else if (bad) r.status = ST_BADEXP;
      else if (sat) r.status = ST_OVERFLOW;
    end else if (mode == MODE_FINISH) begin
      r.value = pop_entry(under);
      if (under) r.status = ST_UNDERFLOW;
    end
    r.depth = 5'(fill_level);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_level = 0;
      result_q.delete();
    end else begin
      if (start && !busy) result_q.push_back(evaluate_token(in_mode, in_op_code,
                                                            in_operand_value));
      if (out_valid) begin
        words_checked++;
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: value %h status %0d depth %0d",
                     out_result_value, out_status, out_stack_depth);
        end else begin
          want = result_q.pop_front();
          if (out_result_value !== want.value || out_status !== want.status ||
              out_stack_depth !== want.depth) begin
            fail_count++;
            if (fail_count <= 10)
              $display("word %0d mismatch: exp value %h status %0d depth %0d, got %h %0d %0d",
                       words_checked, want.value, want.status, want.depth,
                       out_result_value, out_status, out_stack_depth);
          end
        end
      end
    end
    expected_left = result_q.size();
  end

endmodule

[tb/sv/tb_postfix_stack_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator: token-level test of the postfix stack evaluator
// Directed corner tokens, then random postfix expressions mixed with stray
// tokens, sent with random gaps; a separate checker predicts every word.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator;
  import pse_pkg::*;

  localparam int         TARGET_TOKENS = 750;
  localparam int         STALL_LIMIT   = 1000;
  localparam logic [2:0] OP_SPARE_LO   = 3'd6;
  localparam logic [2:0] OP_SPARE_HI   = 3'd7;
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = MODE_PUSH;
  logic [2:0]  in_op_code = OP_ADD;
  logic [31:0] in_operand_value = '0;
  logic        out_valid;
  logic [31:0] out_result_value;
  logic [2:0]  out_status;
  logic [4:0]  out_stack_depth;

  int expected_left, words_checked, fail_count;
  int useful_sent = 0;
  int ignored_sent = 0;
  int push_sent = 0;
  int oper_sent = 0;
  int finish_sent = 0;
  int idle_pct = 18;
  int stall = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  postfix_stack_evaluator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_op_code(in_op_code), .in_operand_value(in_operand_value),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_status(out_status), .out_stack_depth(out_stack_depth)
  );

  pse_result_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_op_code(in_op_code), .in_operand_value(in_operand_value),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_status(out_status), .out_stack_depth(out_stack_depth),
    .expected_left(expected_left), .words_checked(words_checked),
    .fail_count(fail_count)
  );

  task automatic send_word(input logic [1:0] mode, input logic [2:0] code,
                           input logic [31:0] value);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_op_code <= code;
    in_operand_value <= value;
    do @(posedge clk); while (busy);
    if (mode == MODE_SPARE || (mode == MODE_OPER && code > OP_POW)) begin
      ignored_sent++;
    end else begin
      useful_sent++;
      if (mode == MODE_PUSH) push_sent++;
      else if (mode == MODE_OPER) oper_sent++;
      else finish_sent++;
    end
  endtask

  task automatic push_word(input logic [31:0] value);
    send_word(MODE_PUSH, 3'($urandom), value);
  endtask

  task automatic oper_word(input logic [2:0] code);
    send_word(MODE_OPER, code, $urandom);
  endtask

  task automatic finish_word();
    send_word(MODE_FINISH, 3'($urandom), $urandom);
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int sel, k;
    sel = $urandom_range(0, 7);
    k = $urandom_range(0, 32) - 16;
    case (sel)
      0, 1: return $urandom;
      2:    return 32'(k * 65536);
      3:    return 32'(k * 65536) + 32'($urandom_range(0, 65535));
      4:    return 32'($urandom_range(0, 31) * 65536);
      5:    return Q_ONE + 32'(k * 256);
      6:    return 32'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ONE;
          3: return Q_MINUS_ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // nested: all operands first, then the operators; otherwise a running chain
  task automatic run_expression(input int terms, input bit nested);
    logic [2:0]  code;
    logic [31:0] rhs;
    push_word(pick_value());
    if (nested) begin
      for (int i = 1; i < terms; i++) push_word(pick_value());
      for (int i = 1; i < terms; i++) oper_word(3'($urandom_range(0, 5)));
    end else begin
      for (int i = 1; i < terms; i++) begin
        code = 3'($urandom_range(0, 5));
        rhs = pick_value();
        if (code == OP_POW && $urandom_range(0, 3) != 0)
          rhs = 32'($urandom_range(0, 31) * 65536);
        else if ((code == OP_DIV || code == OP_MOD) && $urandom_range(0, 7) == 0)
          rhs = 32'($urandom_range(0, 65535));
        push_word(rhs);
        oper_word(code);
      end
    end
    finish_word();
  endtask

  initial begin
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall = 0;
      else stall++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int sel;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // corner tokens on an empty and then partly filled stack
    finish_word();
    oper_word(OP_ADD);
    oper_word(OP_SPARE_LO);
    oper_word(OP_SPARE_HI);
    send_word(MODE_SPARE, OP_ADD, Q_MAX);
    push_word(Q_MAX);
    push_word(Q_MAX);
    oper_word(OP_ADD);
    push_word(Q_MIN);
    oper_word(OP_MUL);
    push_word(32'h0000_0001);
    oper_word(OP_DIV);
    push_word('0);
    oper_word(OP_DIV);
    push_word(32'hFFF9_0000);
    push_word(32'h0003_0000);
    oper_word(OP_MOD);
    push_word(32'h0000_8000);
    oper_word(OP_MOD);
    push_word(32'h0002_0000);
    push_word(32'h0003_0000);
    oper_word(OP_POW);
    push_word(32'h0001_8000);
    oper_word(OP_POW);
    push_word(32'h0020_0000);
    oper_word(OP_POW);
    push_word(Q_MINUS_ONE);
    oper_word(OP_POW);
    oper_word(OP_SUB);
    repeat (4) finish_word();
    // fill past the top
    repeat (STACK_DEPTH_DEF + 1) push_word(pick_value());
    drain();

    while (useful_sent < TARGET_TOKENS) begin
      idle_pct = (useful_sent >= 350 && useful_sent < 500) ? 0 : 18;
      if (useful_sent >= 600 && useful_sent < 610) drain();
      sel = $urandom_range(0, 99);
      if (sel < 72) run_expression($urandom_range(1, 5), 1'b0);
      else if (sel < 80) run_expression($urandom_range(3, 18), 1'b1);
      else send_word(2'($urandom), 3'($urandom), pick_value());
    end

    @(negedge clk) start <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    $display("Sent %0d tokens: %0d push, %0d operator, %0d finish, %0d ignored codes.",
             useful_sent + ignored_sent, push_sent, oper_sent, finish_sent, ignored_sent);
    $display("Checked %0d result words, %0d failures.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pse_pkg.sv
hdl/pse_ram.sv
hdl/pse_alu.sv
hdl/postfix_stack_evaluator.sv
hdl/pse_checker.sv
tb/sv/pse_result_checker.sv
tb/sv/tb_postfix_stack_evaluator.sv
